// File: sv/separable_conv2d_clamp_macros.svh
// assertion macros for the separable convolution block
`ifndef SEPARABLE_CONV2D_CLAMP_MACROS_SVH
`define SEPARABLE_CONV2D_CLAMP_MACROS_SVH

// property checked only out of reset
`define SCC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");

// property checked at every edge, reset included
`define SCC_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) else $error("assertion failed");

`endif

// File: sv/scc_pkg.sv
package scc_pkg;

  localparam int MaxWidth   = 1024;
  localparam int MaxRadius  = 3;
  localparam int WinLen     = 2 * MaxRadius + 1;
  localparam int ColW       = $clog2(MaxWidth);
  localparam int RowSelW    = $clog2(WinLen);
  localparam int StoreDepth = WinLen * MaxWidth;
  localparam int AddrW      = RowSelW + ColW;
  localparam int WidthW     = 11;
  localparam int HeightW    = 16;
  localparam int RadW       = 2;
  localparam int TapW       = 16;
  localparam int PixW       = 16;
  localparam int RowValW    = 20;
  localparam int AccW       = 40;
  localparam int RndW       = AccW - 14;
  localparam int PosW       = 27;

  typedef enum logic {
    OpPixel = 1'b0,
    OpFlush = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    RegWidth  = 3'd0,
    RegHeight = 3'd1,
    RegRadius = 3'd2,
    RegTaps01 = 3'd3,
    RegTaps23 = 3'd4,
    RegTaps45 = 3'd5,
    RegTap6   = 3'd6
  } reg_idx_e;

  // effective settings, already clamped to their working ranges
  typedef struct packed {
    logic [WidthW-1:0]             width;
    logic [HeightW-1:0]            height;
    logic [RadW-1:0]               radius;
    logic [WinLen-1:0][TapW-1:0]   taps;
  } cfg_t;

  typedef struct packed {
    logic            is_pixel;
    logic [PixW-1:0] pixel;
  } item_t;

  function automatic logic signed [TapW-1:0] tap_at(input cfg_t c, input logic [RowSelW-1:0] k);
    logic signed [TapW-1:0] t;
    t = '0;
    if (int'(k) < WinLen) t = c.taps[k];
    return t;
  endfunction

  // drop 14 fraction bits, half up
  function automatic logic signed [RndW-1:0] rnd14(input logic signed [AccW-1:0] a);
    logic signed [AccW-1:0] t;
    t = a + AccW'(8192);
    return RndW'(t >>> 14);
  endfunction

  function automatic logic [RowValW-1:0] row_sat(input logic signed [RndW-1:0] v);
    logic [RowValW-1:0] o;
    if (v > RndW'(524287)) o = 20'h7FFFF;
    else if (v < -RndW'(524288)) o = 20'h80000;
    else o = RowValW'(v);
    return o;
  endfunction

  function automatic logic [PixW-1:0] col_sat(input logic signed [RndW-1:0] v);
    logic [PixW-1:0] o;
    if (v < 0) o = '0;
    else if (v > RndW'(65535)) o = '1;
    else o = PixW'(v);
    return o;
  endfunction

endpackage

// File: sv/scc_regs.sv
module scc_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output scc_pkg::cfg_t     cfg_o
);
  import scc_pkg::*;

  logic [WidthW-1:0]  width_q;
  logic [HeightW-1:0] height_q;
  logic [RadW-1:0]    radius_q;
  logic [31:0]        taps01_q, taps23_q, taps45_q;
  logic [TapW-1:0]    tap6_q;
  logic               wr_en;
  reg_idx_e           idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_e'(paddr[4:2]);

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthW'(1024);
      height_q <= HeightW'(1024);
      radius_q <= RadW'(1);
      taps01_q <= 32'h4000_0000;
      taps23_q <= '0;
      taps45_q <= '0;
      tap6_q   <= '0;
    end else if (wr_en) begin
      unique case (idx)
        RegWidth:  width_q  <= pwdata[WidthW-1:0];
        RegHeight: height_q <= pwdata[HeightW-1:0];
        RegRadius: radius_q <= pwdata[RadW-1:0];
        RegTaps01: taps01_q <= pwdata;
        RegTaps23: taps23_q <= pwdata;
        RegTaps45: taps45_q <= pwdata;
        RegTap6:   tap6_q   <= pwdata[TapW-1:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    prdata = '0;
    unique case (idx)
      RegWidth:  prdata = 32'(width_q);
      RegHeight: prdata = 32'(height_q);
      RegRadius: prdata = 32'(radius_q);
      RegTaps01: prdata = taps01_q;
      RegTaps23: prdata = taps23_q;
      RegTaps45: prdata = taps45_q;
      RegTap6:   prdata = 32'(tap6_q);
      default:   prdata = '0;
    endcase
  end

  // working values, out-of-range settings folded in
  always_comb begin
    if (width_q == '0) cfg_o.width = WidthW'(1);
    else if (width_q > WidthW'(MaxWidth)) cfg_o.width = WidthW'(MaxWidth);
    else cfg_o.width = width_q;
    cfg_o.height  = (height_q == '0) ? HeightW'(1) : height_q;
    cfg_o.radius  = (int'(radius_q) > MaxRadius) ? RadW'(MaxRadius) : radius_q;
    cfg_o.taps[0] = taps01_q[15:0];
    cfg_o.taps[1] = taps01_q[31:16];
    cfg_o.taps[2] = taps23_q[15:0];
    cfg_o.taps[3] = taps23_q[31:16];
    cfg_o.taps[4] = taps45_q[15:0];
    cfg_o.taps[5] = taps45_q[31:16];
    cfg_o.taps[6] = tap6_q;
  end

endmodule

// File: sv/scc_front.sv
module scc_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [15:0]           s_axis_tdata,
  input  logic                  s_axis_tuser,
  output logic                  item_valid_o,
  output scc_pkg::item_t        item_o,
  input  logic                  item_pop_i
);
  import scc_pkg::*;

  item_t      q_mem [2];
  logic [1:0] cnt_q;
  logic       wptr_q, rptr_q;
  logic       push, pop;
  item_t      in_item;

  // classify the incoming transfer
  assign in_item.is_pixel = (op_e'(s_axis_tuser) == OpPixel);
  assign in_item.pixel    = s_axis_tdata;

  assign s_axis_tready = (cnt_q != 2'd2);
  assign push          = s_axis_tvalid & s_axis_tready;
  assign pop           = item_pop_i & (cnt_q != 2'd0);
  assign item_valid_o  = (cnt_q != 2'd0);
  assign item_o        = q_mem[rptr_q];

  // two-entry queue storage
  always_ff @(posedge clk_i) begin
    if (push) q_mem[wptr_q] <= in_item;
  end

  // queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
    end else begin
      if (push) wptr_q <= ~wptr_q;
      if (pop)  rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

endmodule

// File: sv/scc_back.sv
module scc_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  scc_pkg::cfg_t     cfg_i,
  input  logic              item_valid_i,
  input  scc_pkg::item_t    item_i,
  output logic              item_pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [15:0]       out_pixel_o,
  output logic              out_last_o
);
  import scc_pkg::*;

  typedef enum logic [10:0] {
    StIdle   = 11'b000_0000_0001,
    StNext   = 11'b000_0000_0010,
    StRowMac = 11'b000_0000_0100,
    StRowWr  = 11'b000_0000_1000,
    StAdv    = 11'b000_0001_0000,
    StPos0   = 11'b000_0010_0000,
    StPos1   = 11'b000_0100_0000,
    StPos2   = 11'b000_1000_0000,
    StDecide = 11'b001_0000_0000,
    StColMac = 11'b010_0000_0000,
    StOut    = 11'b100_0000_0000
  } state_e;

  state_e                  state_q;
  logic [PixW-1:0]         win_q [WinLen];
  logic [PixW-1:0]         win_d [WinLen];
  logic [PixW-1:0]         win_shift [WinLen];
  logic [PixW-1:0]         shift_pix;
  logic [ColW-1:0]         in_col_q, out_col_q;
  logic [HeightW-1:0]      in_row_q, out_row_q;
  logic [RowSelW-1:0]      in_rm_q, out_rm_q, cym_q;
  logic [PixW-1:0]         pix_q;
  logic                    last_q;
  logic [RadW-1:0]         s_q;
  logic [RowSelW-1:0]      k_q;
  logic                    v1_q, v2_q;
  logic signed [TapW-1:0]  tap_q;
  logic [PixW-1:0]         win_b_q;
  logic signed [20:0]      mul_b;
  logic signed [36:0]      prod_q;
  logic signed [AccW-1:0]  acc_q;
  logic [PosW-1:0]         n_in_q, n_out_q, total_q;
  logic signed [17:0]      ct_q;
  logic [RowValW-1:0]      store_q [StoreDepth];
  logic [RowValW-1:0]      rdata_q;
  logic [AddrW-1:0]        raddr, waddr;
  logic                    we;
  logic                    out_valid_q, out_last_q;
  logic [PixW-1:0]         out_pixel_q;

  logic [RowSelW-1:0]      r2;
  logic                    mac_st, issue, mac_done, take, out_load;
  logic [WidthW:0]         ix_s;
  logic [ColW-1:0]         rcol;
  logic [HeightW-1:0]      pos_a;
  logic [ColW-1:0]         pos_c;
  logic [PosW-1:0]         pos_val;
  logic [12:0]             span;
  logic [PosW-1:0]         n_diff, n_new;
  logic                    in_done, out_wrap, start_col;
  logic signed [17:0]      t0, tn, hm1;
  logic signed [3:0]       d7;
  logic [RowSelW-1:0]      cym0;

  assign r2       = {cfg_i.radius, 1'b0};
  assign mac_st   = (state_q == StRowMac) || (state_q == StColMac);
  assign issue    = mac_st && (k_q <= r2);
  assign mac_done = !issue && !v1_q && !v2_q;
  assign take     = (state_q == StIdle) && item_valid_i;
  assign item_pop_o = take;
  assign in_done  = (in_row_q >= cfg_i.height);
  assign ix_s     = (WidthW+1)'(in_col_q) + (WidthW+1)'(s_q);
  assign rcol     = ColW'(ix_s - (WidthW+1)'(cfg_i.radius));
  assign out_load = (state_q == StOut) && (!out_valid_q || out_ready_i);
  assign out_wrap = (WidthW'(out_col_q) + WidthW'(1)) >= cfg_i.width;

  // window shifted by one within the active taps
  assign shift_pix = (state_q == StIdle) ? item_i.pixel : pix_q;
  always_comb begin
    for (int j = 0; j < WinLen; j++) begin
      if (RowSelW'(j) == r2) win_shift[j] = shift_pix;
      else if (RowSelW'(j) < r2) win_shift[j] = win_q[(j + 1) % WinLen];
      else win_shift[j] = win_q[j];
    end
  end

  always_comb begin
    win_d = win_q;
    if (take && item_i.is_pixel && !in_done) begin
      if (in_col_q == '0) begin
        for (int j = 0; j < WinLen; j++) win_d[j] = item_i.pixel;
      end else begin
        win_d = win_shift;
      end
    end else if (state_q == StAdv && last_q && s_q < cfg_i.radius) begin
      win_d = win_shift;
    end
  end

  // shared position multiplier
  always_comb begin
    pos_a = cfg_i.height;
    pos_c = '0;
    if (state_q == StPos0) begin
      pos_a = in_row_q;
      pos_c = in_col_q;
    end else if (state_q == StPos1) begin
      pos_a = out_row_q;
      pos_c = out_col_q;
    end
    pos_val = PosW'(pos_a) * PosW'(cfg_i.width) + PosW'(pos_c);
  end

  // lag window of r rows plus r pixels
  assign span      = 13'(cfg_i.width) * 13'(cfg_i.radius) + 13'(cfg_i.radius);
  assign n_diff    = n_in_q - n_out_q;
  assign start_col = !in_done ? ((n_in_q > n_out_q) && (n_diff > PosW'(span))) : 1'b1;

  // first row of the column window, clamped at the top
  assign t0   = $signed({2'b0, out_row_q}) - $signed({16'b0, cfg_i.radius});
  assign d7   = $signed({1'b0, out_rm_q}) - $signed({2'b0, cfg_i.radius});
  assign cym0 = (t0 < 0) ? '0 : ((d7 < 0) ? RowSelW'(d7 + 4'sd7) : RowSelW'(d7));
  assign tn   = ct_q + 18'sd1;
  assign hm1  = $signed({2'b0, cfg_i.height}) - 18'sd1;

  // next linear output position
  assign n_new = out_wrap ? (n_out_q - PosW'(out_col_q) + PosW'(cfg_i.width))
                          : (n_out_q + PosW'(1));

  // line store ports
  assign raddr = {cym_q, out_col_q};
  assign waddr = {in_rm_q, rcol};
  assign we    = (state_q == StRowWr);

  always_ff @(posedge clk_i) begin
    if (we) store_q[waddr] <= row_sat(rnd14(acc_q));
    rdata_q <= store_q[raddr];
  end

  // multiply-accumulate pipeline: operand fetch, product, sum
  assign mul_b = (state_q == StRowMac) ? $signed({5'b0, win_b_q})
                                       : $signed({rdata_q[RowValW-1], rdata_q});
  always_ff @(posedge clk_i) begin
    if (issue) begin
      tap_q   <= tap_at(cfg_i, k_q);
      win_b_q <= win_q[k_q];
    end
    prod_q <= tap_q * mul_b;
    win_q  <= win_d;
    if (take) pix_q <= item_i.pixel;
    if (state_q == StPos0) n_in_q  <= pos_val;
    if (state_q == StPos1) n_out_q <= pos_val;
    if (state_q == StPos2) total_q <= pos_val;
    if (out_load) out_pixel_q <= col_sat(rnd14(acc_q));
  end

  // sequencer and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      in_col_q    <= '0;
      in_row_q    <= '0;
      in_rm_q     <= '0;
      out_col_q   <= '0;
      out_row_q   <= '0;
      out_rm_q    <= '0;
      last_q      <= 1'b0;
      s_q         <= '0;
      k_q         <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      acc_q       <= '0;
      ct_q        <= '0;
      cym_q       <= '0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      v1_q <= issue;
      v2_q <= v1_q;
      if (issue) k_q <= k_q + RowSelW'(1);
      if (v2_q) acc_q <= acc_q + AccW'(prod_q);
      if (out_valid_q && out_ready_i && !out_load) out_valid_q <= 1'b0;

      unique case (state_q)
        StIdle: begin
          if (take) begin
            if (item_i.is_pixel && !in_done) begin
              last_q  <= (WidthW'(in_col_q) + WidthW'(1)) >= cfg_i.width;
              s_q     <= '0;
              state_q <= StNext;
            end else begin
              state_q <= StPos0;
            end
          end
        end
        StNext: begin
          if (ix_s >= (WidthW+1)'(cfg_i.radius)) begin
            k_q     <= '0;
            acc_q   <= '0;
            state_q <= StRowMac;
          end else begin
            state_q <= StAdv;
          end
        end
        StRowMac: begin
          if (mac_done) state_q <= StRowWr;
        end
        StRowWr: state_q <= StAdv;
        StAdv: begin
          if (last_q && s_q < cfg_i.radius) begin
            s_q     <= s_q + RadW'(1);
            state_q <= StNext;
          end else begin
            if (last_q) begin
              in_col_q <= '0;
              in_row_q <= in_row_q + HeightW'(1);
              in_rm_q  <= (int'(in_rm_q) == WinLen - 1) ? '0 : in_rm_q + RowSelW'(1);
            end else begin
              in_col_q <= in_col_q + ColW'(1);
            end
            state_q <= StPos0;
          end
        end
        StPos0: state_q <= StPos1;
        StPos1: state_q <= StPos2;
        StPos2: state_q <= StDecide;
        StDecide: begin
          if (n_out_q >= total_q) begin
            if (in_done) begin
              in_col_q  <= '0;
              in_row_q  <= '0;
              in_rm_q   <= '0;
              out_col_q <= '0;
              out_row_q <= '0;
              out_rm_q  <= '0;
            end
            state_q <= StIdle;
          end else if (start_col) begin
            ct_q    <= t0;
            cym_q   <= cym0;
            k_q     <= '0;
            acc_q   <= '0;
            state_q <= StColMac;
          end else begin
            state_q <= StIdle;
          end
        end
        StColMac: begin
          if (issue) begin
            ct_q <= tn;
            if (tn > 0 && tn <= hm1) begin
              cym_q <= (int'(cym_q) == WinLen - 1) ? '0 : cym_q + RowSelW'(1);
            end
          end
          if (mac_done) state_q <= StOut;
        end
        StOut: begin
          if (out_load) begin
            out_valid_q <= 1'b1;
            out_last_q  <= (n_new >= total_q);
            if (n_new >= total_q) begin
              in_col_q  <= '0;
              in_row_q  <= '0;
              in_rm_q   <= '0;
              out_col_q <= '0;
              out_row_q <= '0;
              out_rm_q  <= '0;
            end else if (out_wrap) begin
              out_col_q <= '0;
              out_row_q <= out_row_q + HeightW'(1);
              out_rm_q  <= (int'(out_rm_q) == WinLen - 1) ? '0 : out_rm_q + RowSelW'(1);
            end else begin
              out_col_q <= out_col_q + ColW'(1);
            end
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_pixel_o = out_pixel_q;
  assign out_last_o  = out_last_q;

endmodule

// File: sv/separable_conv2d_clamp.sv
// channel   | dir | transfer when         | payload
// s_axis    | in  | tvalid & tready       | tdata: pixel_in; tuser: operation
// m_axis    | out | tvalid & tready       | tdata: pixel_out; tlast: frame_last
// apb       | in  | psel&penable&pwrite   | seven registers at byte address 4*i
//
// one item at a time: the back end takes no new item until it is done with the
// previous one, and the row results, the r extra row results at the end of a row
// and the column results all go through the one shared multiply-accumulate unit
// a two-entry input queue and an output register decouple both sides
// asynchronous active-low reset; the line store holds no reset value
module separable_conv2d_clamp (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] pixel_in
  input  logic        s_axis_tuser,   // [0] operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] pixel_out
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import scc_pkg::*;

  cfg_t  cfg;
  item_t item;
  logic  item_valid, item_pop;

  // configuration registers
  scc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // input queue and classification
  scc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .item_valid_o  (item_valid),
    .item_o        (item),
    .item_pop_i    (item_pop)
  );

  // filter engine
  scc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_pop_o   (item_pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_pixel_o  (m_axis_tdata),
    .out_last_o   (m_axis_tlast)
  );

endmodule

// File: sv/scc_checker.sv
`include "separable_conv2d_clamp_macros.svh"

module scc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [15:0] s_axis_tdata,
  input logic        s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tlast,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [4:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata,
  input logic        pready
);

  // a stalled result stays offered
  `SCC_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)

  // a stalled result keeps its pixel
  `SCC_ASSERT(a_out_stable, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))

  // register port never waits
  `SCC_ASSERT_ALWAYS(a_pready, pready)

  // reset clears the offered result
  `SCC_ASSERT_ALWAYS(a_rst_quiet, !rst_ni |=> !m_axis_tvalid)

endmodule

bind separable_conv2d_clamp scc_checker u_scc_checker (.*);

// File: tb/sv/separable_conv2d_clamp_test.sv
module separable_conv2d_clamp_test;
  import scc_pkg::*;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;   // [15:0] pixel_in
  logic        s_axis_tuser = 1'b0; // [0] operation
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;        // [15:0] pixel_out
  logic        m_axis_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  separable_conv2d_clamp u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  typedef struct {
    op_e         op;
    logic [15:0] pixel;
  } pix_item_t;

  typedef struct {
    logic [15:0] pixel;
    bit          last;
  } out_pix_t;

  pix_item_t pending_pixels[$];
  out_pix_t  expected_pixels[$];
  int        n_items;
  int        n_fail;
  int        hold_ticket;
  int        hold_seen;
  int        hold_cnt;
  int        rdy_run;
  int        gap_cnt;
  int        burst_cnt;

  // shadow of the block: registers, row window, line store, positions
  logic [10:0] cfg_width;
  logic [15:0] cfg_height;
  logic [1:0]  cfg_radius;
  logic [31:0] cfg_taps01, cfg_taps23, cfg_taps45;
  logic [15:0] cfg_tap6;
  logic [15:0] row_win[WinLen];
  int          row_lines[WinLen * MaxWidth];
  int          in_col, in_row, out_col, out_row;

  function automatic longint tap_of(input int k);
    logic [15:0] t;
    case (k)
      0: t = cfg_taps01[15:0];
      1: t = cfg_taps01[31:16];
      2: t = cfg_taps23[15:0];
      3: t = cfg_taps23[31:16];
      4: t = cfg_taps45[15:0];
      5: t = cfg_taps45[31:16];
      6: t = cfg_tap6;
      default: t = '0;
    endcase
    return longint'($signed(t));
  endfunction

  function automatic void slide_row(input int r, input logic [15:0] p);
    for (int j = 0; j < 2 * r; j++) row_win[j] = row_win[j+1];
    row_win[2*r] = p;
  endfunction

  // horizontal pass result into the line store, rounded and saturated to 20 bits
  function automatic void store_row_value(input int r, input int col);
    longint acc;
    acc = 0;
    for (int k = 0; k <= 2 * r; k++) acc += tap_of(k) * longint'(row_win[k]);
    acc = (acc + 8192) >>> 14;
    if (acc > 524287) acc = 524287;
    if (acc < -524288) acc = -524288;
    row_lines[(in_row % WinLen) * MaxWidth + (col % MaxWidth)] = int'(acc);
  endfunction

  function automatic bit predict_pixel(input op_e op, input logic [15:0] p,
                                       output out_pix_t res);
    int     w, h, r, ix, y;
    longint total, n_in, n_out, acc;
    w = (cfg_width == 0) ? 1 : (cfg_width > MaxWidth ? MaxWidth : int'(cfg_width));
    h = (cfg_height == 0) ? 1 : int'(cfg_height);
    r = int'(cfg_radius);
    total = longint'(h) * w;
    res.pixel = '0;
    res.last = 1'b0;
    if (op == OpPixel && in_row < h) begin
      ix = in_col;
      if (ix == 0) begin
        for (int j = 0; j < WinLen; j++) row_win[j] = p;
      end else begin
        slide_row(r, p);
      end
      if (ix >= r) store_row_value(r, ix - r);
      if (ix + 1 >= w) begin
        for (int s = 1; s <= r; s++) begin
          slide_row(r, p);
          if (ix + s >= r) store_row_value(r, ix + s - r);
        end
        in_col = 0;
        in_row++;
      end else begin
        in_col++;
      end
    end
    n_in = longint'(in_row) * w + in_col;
    n_out = longint'(out_row) * w + out_col;
    if (n_out >= total) begin
      if (in_row >= h) begin
        in_col = 0; in_row = 0; out_col = 0; out_row = 0;
      end
      return 1'b0;
    end
    if (!(in_row >= h || (n_in > n_out && n_in - n_out > longint'(r) * w + r)))
      return 1'b0;
    // vertical pass with top and bottom rows repeated
    acc = 0;
    for (int k = 0; k <= 2 * r; k++) begin
      y = out_row - r + k;
      if (y < 0) y = 0;
      if (y > h - 1) y = h - 1;
      acc += tap_of(k) * longint'(row_lines[(y % WinLen) * MaxWidth + (out_col % MaxWidth)]);
    end
    acc = (acc + 8192) >>> 14;
    if (acc < 0) acc = 0;
    if (acc > 65535) acc = 65535;
    res.pixel = acc[15:0];
    if (out_col + 1 >= w) begin
      out_col = 0;
      out_row++;
    end else begin
      out_col++;
    end
    if (longint'(out_row) * w + out_col >= total) begin
      res.last = 1'b1;
      in_col = 0; in_row = 0; out_col = 0; out_row = 0;
    end
    return 1'b1;
  endfunction

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // input driver: one transfer per handshake, random gaps between items
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      gap_cnt <= 0;
      burst_cnt <= 0;
    end else if (!(s_axis_tvalid && !s_axis_tready)) begin
      if (gap_cnt > 0) begin
        gap_cnt <= gap_cnt - 1;
        s_axis_tvalid <= 1'b0;
      end else if (pending_pixels.size() > 0) begin
        pix_item_t it;
        int        roll;
        it = pending_pixels.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= it.pixel;
        s_axis_tuser <= it.op;
        roll = $urandom_range(99);
        if (burst_cnt > 0) begin
          burst_cnt <= burst_cnt - 1;
          gap_cnt <= 0;
        end else if (roll < 8) begin
          burst_cnt <= $urandom_range(60, 20);
        end else if (roll < 60) begin
          gap_cnt <= 0;
        end else if (roll < 95) begin
          gap_cnt <= $urandom_range(4, 1);
        end else begin
          gap_cnt <= $urandom_range(120, 20);
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // output monitor and receiver stalls
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      hold_cnt <= 0;
      hold_seen <= 0;
      rdy_run <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_pixels.size() == 0) begin
          $display("%0t: unexpected transfer pixel %h last %b", $time,
                   m_axis_tdata, m_axis_tlast);
          n_fail++;
        end else begin
          out_pix_t e;
          e = expected_pixels.pop_front();
          if (m_axis_tdata !== e.pixel) begin
            $display("%0t: pixel_out expected %h actual %h", $time, e.pixel, m_axis_tdata);
            n_fail++;
          end
          if (m_axis_tlast !== e.last) begin
            $display("%0t: frame_last expected %b actual %b", $time, e.last, m_axis_tlast);
            n_fail++;
          end
        end
      end
      if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
        m_axis_tready <= 1'b0;
      end else if (hold_ticket != hold_seen) begin
        hold_seen <= hold_ticket;
        hold_cnt <= 700;
        m_axis_tready <= 1'b0;
      end else if (rdy_run > 0) begin
        rdy_run <= rdy_run - 1;
        m_axis_tready <= 1'b1;
      end else begin
        int roll;
        roll = $urandom_range(99);
        if (roll < 8) begin
          rdy_run <= $urandom_range(80, 20);
          m_axis_tready <= 1'b1;
        end else if (roll < 65) begin
          m_axis_tready <= 1'b1;
        end else if (roll < 96) begin
          m_axis_tready <= 1'b0;
        end else begin
          m_axis_tready <= 1'b0;
          hold_cnt <= $urandom_range(80, 10);
        end
      end
    end
  end

  task automatic push_pixel(input op_e op, input logic [15:0] p, output bit last);
    out_pix_t res;
    pix_item_t it;
    last = 1'b0;
    it.op = op;
    it.pixel = p;
    pending_pixels.push_back(it);
    n_items++;
    if (predict_pixel(op, p, res)) begin
      expected_pixels.push_back(res);
      last = res.last;
    end
  endtask

  task automatic wait_idle();
    while (pending_pixels.size() > 0 || s_axis_tvalid || expected_pixels.size() > 0)
      @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      RegWidth:  cfg_width = val[10:0];
      RegHeight: cfg_height = val[15:0];
      RegRadius: cfg_radius = val[1:0];
      RegTaps01: cfg_taps01 = val;
      RegTaps23: cfg_taps23 = val;
      RegTaps45: cfg_taps45 = val;
      default:   cfg_tap6 = val[15:0];
    endcase
  endtask

  function automatic logic [15:0] pick_tap();
    int roll;
    roll = $urandom_range(9);
    case (roll)
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'h4000;
      4, 5: return 16'($urandom_range(8192));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_pixel();
    int roll;
    roll = $urandom_range(9);
    if (roll == 0) return 16'h0000;
    if (roll == 1) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  task automatic setup(input logic [10:0] w, input logic [15:0] h, input logic [1:0] r,
                       input bit rand_taps);
    wait_idle();
    write_reg(RegWidth, {21'($urandom), w});
    write_reg(RegHeight, {16'($urandom), h});
    write_reg(RegRadius, {30'($urandom), r});
    if (rand_taps) begin
      write_reg(RegTaps01, {pick_tap(), pick_tap()});
      write_reg(RegTaps23, {pick_tap(), pick_tap()});
      write_reg(RegTaps45, {pick_tap(), pick_tap()});
      write_reg(RegTap6, {16'($urandom), pick_tap()});
    end
  endtask

  // one whole frame, with stray flushes inside and stray pixels in the drain
  task automatic run_frame(input int noise, input int pause_at);
    int w, h;
    bit last;
    w = (cfg_width == 0) ? 1 : (cfg_width > MaxWidth ? MaxWidth : int'(cfg_width));
    h = (cfg_height == 0) ? 1 : int'(cfg_height);
    for (int i = 0; i < w * h; i++) begin
      if (i == pause_at) begin
        while (pending_pixels.size() > 0 || s_axis_tvalid) @(posedge clk_i);
        while (expected_pixels.size() > 0) @(posedge clk_i);
      end
      if ($urandom_range(99) < noise) push_pixel(OpFlush, 16'($urandom), last);
      push_pixel(OpPixel, pick_pixel(), last);
    end
    while (!last) begin
      if ($urandom_range(99) < noise * 2) push_pixel(OpPixel, 16'($urandom), last);
      else push_pixel(OpFlush, 16'($urandom), last);
    end
  endtask

  initial begin
    bit last;
    n_items = 0;
    n_fail = 0;
    hold_ticket = 0;
    cfg_width = 11'd1024;
    cfg_height = 16'd1024;
    cfg_radius = 2'd1;
    cfg_taps01 = 32'h4000_0000;
    cfg_taps23 = '0;
    cfg_taps45 = '0;
    cfg_tap6 = '0;
    for (int j = 0; j < WinLen; j++) row_win[j] = '0;
    for (int j = 0; j < WinLen * MaxWidth; j++) row_lines[j] = 0;
    in_col = 0; in_row = 0; out_col = 0; out_row = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // single pixel frames, width and height zero acting as one
    setup(11'd0, 16'd0, 2'd0, 1'b0);
    push_pixel(OpFlush, 16'hFFFF, last);
    run_frame(0, -1);
    push_pixel(OpPixel, 16'h0000, last);
    push_pixel(OpPixel, 16'hFFFF, last);
    // saturation both ways, widest radius
    setup(11'd3, 16'd2, 2'd3, 1'b0);
    write_reg(RegTaps01, 32'h7FFF_7FFF);
    write_reg(RegTaps23, 32'h7FFF_7FFF);
    write_reg(RegTaps45, 32'h7FFF_7FFF);
    write_reg(RegTap6, 32'hFFFF_7FFF);
    for (int i = 0; i < 6; i++) push_pixel(OpPixel, 16'hFFFF, last);
    while (!last) push_pixel(OpPixel, 16'hAAAA, last);
    setup(11'd2, 16'd3, 2'd2, 1'b0);
    write_reg(RegTaps01, 32'h8000_8000);
    write_reg(RegTaps23, 32'h8000_8000);
    write_reg(RegTaps45, 32'h8000_8000);
    write_reg(RegTap6, 32'h0000_8000);
    for (int i = 0; i < 6; i++) push_pixel(OpPixel, (i % 2) ? 16'hFFFF : 16'h5555, last);
    while (!last) push_pixel(OpFlush, 16'h0000, last);
    // full width row, width above the maximum acting as the maximum
    setup(11'h7FF, 16'hFFFF, 2'd1, 1'b1);
    setup(11'h7FF, 16'd1, 2'd0, 1'b1);
    run_frame(2, -1);

    // random frames, mostly small, one long receiver hold and one sender pause
    for (int f = 0; f < 3 || n_items < 1250; f++) begin
      setup($urandom_range(99) < 85 ? 11'($urandom_range(12, 1)) : 11'($urandom_range(40, 13)),
            16'($urandom_range(8) == 0 ? 0 : $urandom_range(8, 1)),
            2'($urandom_range(3)), 1'b1);
      if (f == 1) begin
        setup(11'd12, 16'd4, 2'd0, 1'b1);
        hold_ticket++;
        run_frame(5, -1);
      end else if (f == 2) begin
        setup(11'd10, 16'd6, 2'd2, 1'b1);
        run_frame(5, 35);
      end else begin
        run_frame($urandom_range(10), -1);
      end
    end

    wait_idle();
    if (n_fail == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #4000000;
    $display("FAILURE");
    $finish;
  end

endmodule
